// File: hdl/tls_pkg.sv
// tls_pkg: shared types, codes and constants of the traffic light sequencer
// no dependencies; compiled first
package tls_pkg;

  // widths of counters and fields
  localparam int CNT_W          = 7;
  localparam int YEL_W          = 4;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 7;
  localparam int LAMP_W         = 2;
  localparam int MARK_W         = 2;

  // defaults
  localparam int               DEF_YELLOW_TICKS = 3;
  localparam logic [CNT_W-1:0] CFG_RESET_TICKS  = 7'd5;
  localparam logic [CNT_W-1:0] CNT_MAX          = 7'd127;

  // lamp colours
  typedef enum logic [LAMP_W-1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } lamp_t;

  // phase marks
  typedef enum logic [MARK_W-1:0] {
    MARK_NONE     = 2'd0,
    MARK_CYCLE    = 2'd1,
    MARK_EW_GREEN = 2'd2
  } mark_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NS_GREEN = 8'd0,
    REG_NS_RED   = 8'd1,
    REG_EW_GREEN = 8'd2,
    REG_EW_RED   = 8'd3
  } reg_idx_t;

  // configured phase times
  typedef struct packed {
    logic [CNT_W-1:0] ns_green_ticks;
    logic [CNT_W-1:0] ns_red_ticks;
    logic [CNT_W-1:0] ew_green_ticks;
    logic [CNT_W-1:0] ew_red_ticks;
  } tls_cfg_t;

  // sequencer counters
  typedef struct packed {
    logic [CNT_W-1:0] ns_green_left;
    logic [CNT_W-1:0] ns_red_left;
    logic [CNT_W-1:0] ew_green_left;
    logic [CNT_W-1:0] ew_red_left;
    logic [YEL_W-1:0] ns_yellow_left;
    logic [YEL_W-1:0] ew_yellow_left;
    logic             ew_start_marked;
  } tls_state_t;

  // one result word
  typedef struct packed {
    lamp_t            ns_lamp;
    lamp_t            ew_lamp;
    logic [CNT_W-1:0] ns_countdown;
    logic [CNT_W-1:0] ew_countdown;
    mark_t            phase_mark;
  } tls_result_t;

  // saturating decrement
  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - 1'b1 : '0;
  endfunction

  function automatic logic [YEL_W-1:0] dec_sat_y(input logic [YEL_W-1:0] v);
    return (v != '0) ? v - 1'b1 : '0;
  endfunction

endpackage

// File: hdl/tls_in_if.sv
// tls_in_if: input channel carrying tick words
// depends on nothing
interface tls_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// File: hdl/tls_out_if.sv
// tls_out_if: result channel carrying lamp colours, countdowns and marks
// depends on tls_pkg for field widths
interface tls_out_if
  import tls_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LAMP_W-1:0] ns_lamp;
  logic [LAMP_W-1:0] ew_lamp;
  logic [CNT_W-1:0]  ns_countdown;
  logic [CNT_W-1:0]  ew_countdown;
  logic [MARK_W-1:0] phase_mark;

  modport source (output valid, output ns_lamp, output ew_lamp, output ns_countdown,
                  output ew_countdown, output phase_mark, input ready);
  modport sink   (input valid, input ns_lamp, input ew_lamp, input ns_countdown,
                  input ew_countdown, input phase_mark, output ready);
endinterface

// File: hdl/tls_cfg_if.sv
// tls_cfg_if: configuration write channel (register index and data)
// depends on tls_pkg for field widths
interface tls_cfg_if
  import tls_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/tls_cfg_regs.sv
// tls_cfg_regs: the four phase time registers and their write decoder
// depends on tls_pkg
module tls_cfg_regs
  import tls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output tls_cfg_t              cfg
);

  tls_cfg_t cfg_r;
  tls_cfg_t cfg_nxt;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_NS_GREEN: cfg_nxt.ns_green_ticks = wr_data;
        REG_NS_RED:   cfg_nxt.ns_red_ticks   = wr_data;
        REG_EW_GREEN: cfg_nxt.ew_green_ticks = wr_data;
        REG_EW_RED:   cfg_nxt.ew_red_ticks   = wr_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{CFG_RESET_TICKS, CFG_RESET_TICKS, CFG_RESET_TICKS, CFG_RESET_TICKS};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/tls_step.sv
// tls_step: next-state and result logic for one tick of the sequencer
// depends on tls_pkg
module tls_step
  import tls_pkg::*;
#(
  parameter int YELLOW_TICKS = DEF_YELLOW_TICKS
) (
  input  tls_cfg_t    cfg,
  input  tls_state_t  cur,
  output tls_state_t  nxt,
  output tls_result_t res
);

  // yellow time held at the counter ceiling
  localparam logic [YEL_W-1:0] YellowLoad =
    (YELLOW_TICKS > (2**YEL_W) - 1) ? {YEL_W{1'b1}} : YEL_W'(YELLOW_TICKS);

  logic [CNT_W:0]   ns_red_sum;
  logic [CNT_W:0]   ew_red_sum;
  logic [CNT_W-1:0] ns_red_load;
  logic [CNT_W-1:0] ew_red_load;

  // red reload with yellow extension, saturating at full scale
  always_comb begin
    ns_red_sum  = {1'b0, cfg.ns_red_ticks} + (CNT_W+1)'(YellowLoad);
    ew_red_sum  = {1'b0, cfg.ew_red_ticks} + (CNT_W+1)'(YellowLoad);
    ns_red_load = ns_red_sum[CNT_W] ? CNT_MAX : ns_red_sum[CNT_W-1:0];
    ew_red_load = ew_red_sum[CNT_W] ? CNT_MAX : ew_red_sum[CNT_W-1:0];
  end

  // phase selection by priority of the remaining counters
  always_comb begin
    nxt = cur;
    res.phase_mark = MARK_NONE;
    if (cur.ns_green_left != '0) begin
      nxt.ns_green_left = dec_sat(cur.ns_green_left);
      nxt.ew_red_left   = dec_sat(cur.ew_red_left);
      res.ns_lamp       = LAMP_GREEN;
      res.ew_lamp       = LAMP_RED;
      res.ns_countdown  = nxt.ns_green_left;
      res.ew_countdown  = nxt.ew_red_left;
    end else if (cur.ns_yellow_left != '0) begin
      nxt.ns_yellow_left = dec_sat_y(cur.ns_yellow_left);
      nxt.ew_red_left    = dec_sat(cur.ew_red_left);
      res.ns_lamp        = LAMP_YELLOW;
      res.ew_lamp        = LAMP_RED;
      res.ns_countdown   = CNT_W'(nxt.ns_yellow_left);
      res.ew_countdown   = nxt.ew_red_left;
    end else if (cur.ew_green_left != '0) begin
      if (!cur.ew_start_marked) begin
        res.phase_mark      = MARK_EW_GREEN;
        nxt.ew_start_marked = 1'b1;
      end
      nxt.ns_red_left   = dec_sat(cur.ns_red_left);
      nxt.ew_green_left = dec_sat(cur.ew_green_left);
      res.ns_lamp       = LAMP_RED;
      res.ew_lamp       = LAMP_GREEN;
      res.ns_countdown  = nxt.ns_red_left;
      res.ew_countdown  = nxt.ew_green_left;
    end else if (cur.ew_yellow_left != '0) begin
      nxt.ew_yellow_left = dec_sat_y(cur.ew_yellow_left);
      nxt.ns_red_left    = dec_sat(cur.ns_red_left);
      res.ns_lamp        = LAMP_RED;
      res.ew_lamp        = LAMP_YELLOW;
      res.ns_countdown   = nxt.ns_red_left;
      res.ew_countdown   = CNT_W'(nxt.ew_yellow_left);
    end else begin
      // all spent: reload, and this tick is the first north-south green one
      nxt.ns_green_left   = dec_sat(cfg.ns_green_ticks);
      nxt.ns_red_left     = ns_red_load;
      nxt.ew_green_left   = cfg.ew_green_ticks;
      nxt.ew_red_left     = dec_sat(ew_red_load);
      nxt.ns_yellow_left  = YellowLoad;
      nxt.ew_yellow_left  = YellowLoad;
      nxt.ew_start_marked = 1'b0;
      res.phase_mark      = MARK_CYCLE;
      res.ns_lamp         = LAMP_GREEN;
      res.ew_lamp         = LAMP_RED;
      res.ns_countdown    = nxt.ns_green_left;
      res.ew_countdown    = nxt.ew_red_left;
    end
  end

endmodule

// File: hdl/traffic_light_sequencer_top.sv
// traffic_light_sequencer_top: input register, sequencer state, result register
// depends on tls_pkg, tls_in_if, tls_out_if, tls_cfg_if, tls_cfg_regs, tls_step
// a tick word passes the input register and then the result register before it is offered
// throughput: one word per cycle while the result side takes words; the step logic is one pass over small counters
// a word with tick low is dropped in the input register and gives no result
// synchronous active-low reset clears counters and valids, registers go to 5
module traffic_light_sequencer_top
  import tls_pkg::*;
#(
  parameter int YELLOW_TICKS = DEF_YELLOW_TICKS
) (
  input  logic  clk,
  input  logic  rst_n,
  tls_in_if.sink    in_ch,
  tls_out_if.source out_ch,
  tls_cfg_if.sink   cfg_ch
);

  tls_cfg_t    cfg;
  tls_state_t  state_r;
  tls_state_t  state_nxt;
  tls_result_t step_res;
  tls_result_t res_r;

  logic s1_valid_r;
  logic s1_tick_r;
  logic out_valid_r;
  logic s1_go;
  logic in_take;

  // configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  tls_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  tls_step #(
    .YELLOW_TICKS (YELLOW_TICKS)
  ) u_step (
    .cfg (cfg),
    .cur (state_r),
    .nxt (state_nxt),
    .res (step_res)
  );

  // handshake: a zero tick always leaves, a real tick needs room downstream
  assign s1_go       = s1_valid_r && (!s1_tick_r || !out_valid_r || out_ch.ready);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick_r <= in_ch.tick;
    end
  end

  // sequencer state advances when a real tick moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_go && s1_tick_r) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_tick_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tick_r) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ns_lamp      = res_r.ns_lamp;
  assign out_ch.ew_lamp      = res_r.ew_lamp;
  assign out_ch.ns_countdown = res_r.ns_countdown;
  assign out_ch.ew_countdown = res_r.ew_countdown;
  assign out_ch.phase_mark   = res_r.phase_mark;

endmodule

// File: sim/tb.sv
// tb: self-checking bench for traffic_light_sequencer_top, runs tick words through the dut
// and compares every result word with a tick-by-tick prediction of the light sequence
// depends on tls_pkg, tls_in_if, tls_out_if, tls_cfg_if and the dut sources under hdl
module tb
  import tls_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int YELLOW      = DEF_YELLOW_TICKS;
  localparam int TICK_GOAL   = 1800;
  localparam int DRAIN       = 6;
  localparam int LONG_HOLD   = 150;
  localparam int CYCLE_LIMIT = 400000;

  // light sequence prediction and the queue of result words still owed by the dut
  class lamp_scoreboard;
    tls_cfg_t         times;
    tls_state_t       st;
    logic [YEL_W-1:0] yellow_load;
    tls_result_t      pending_lamps[$];
    int unsigned      errors;

    function new(int yellow);
      yellow_load = (yellow > 15) ? YEL_W'(15) : YEL_W'(yellow);
      times = {4{CFG_RESET_TICKS}};
      st = '0;
      errors = 0;
    endfunction

    function logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] v);
      return (v == '0) ? '0 : v - 1'b1;
    endfunction

    // red time stretched by the yellow phase, held at the counter ceiling
    function logic [CNT_W-1:0] red_reload(logic [CNT_W-1:0] base);
      int s;
      s = int'(base) + int'(yellow_load);
      return (s > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(s);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NS_GREEN: times.ns_green_ticks = val;
        REG_NS_RED:   times.ns_red_ticks   = val;
        REG_EW_GREEN: times.ew_green_ticks = val;
        REG_EW_RED:   times.ew_red_ticks   = val;
        default: ;
      endcase
    endfunction

    // one accepted tick word: advance the sequence and owe one result word
    function void note_tick(logic t);
      tls_result_t w;
      if (t != 1'b1) return;
      w.phase_mark = MARK_NONE;
      if (st.ns_green_left != '0) begin
        st.ns_green_left = st.ns_green_left - 1'b1;
        st.ew_red_left   = count_down(st.ew_red_left);
        w.ns_lamp = LAMP_GREEN;
        w.ew_lamp = LAMP_RED;
        w.ns_countdown = st.ns_green_left;
        w.ew_countdown = st.ew_red_left;
      end else if (st.ns_yellow_left != '0) begin
        st.ns_yellow_left = st.ns_yellow_left - 1'b1;
        st.ew_red_left    = count_down(st.ew_red_left);
        w.ns_lamp = LAMP_YELLOW;
        w.ew_lamp = LAMP_RED;
        w.ns_countdown = CNT_W'(st.ns_yellow_left);
        w.ew_countdown = st.ew_red_left;
      end else if (st.ew_green_left != '0) begin
        if (!st.ew_start_marked) begin
          w.phase_mark = MARK_EW_GREEN;
          st.ew_start_marked = 1'b1;
        end
        st.ns_red_left   = count_down(st.ns_red_left);
        st.ew_green_left = st.ew_green_left - 1'b1;
        w.ns_lamp = LAMP_RED;
        w.ew_lamp = LAMP_GREEN;
        w.ns_countdown = st.ns_red_left;
        w.ew_countdown = st.ew_green_left;
      end else if (st.ew_yellow_left != '0) begin
        st.ew_yellow_left = st.ew_yellow_left - 1'b1;
        st.ns_red_left    = count_down(st.ns_red_left);
        w.ns_lamp = LAMP_RED;
        w.ew_lamp = LAMP_YELLOW;
        w.ns_countdown = st.ns_red_left;
        w.ew_countdown = CNT_W'(st.ew_yellow_left);
      end else begin
        // all spent: reload, and this tick is already the first north-south green one
        st.ns_green_left   = count_down(times.ns_green_ticks);
        st.ns_red_left     = red_reload(times.ns_red_ticks);
        st.ew_green_left   = times.ew_green_ticks;
        st.ew_red_left     = count_down(red_reload(times.ew_red_ticks));
        st.ns_yellow_left  = yellow_load;
        st.ew_yellow_left  = yellow_load;
        st.ew_start_marked = 1'b0;
        w.ns_lamp = LAMP_GREEN;
        w.ew_lamp = LAMP_RED;
        w.ns_countdown = st.ns_green_left;
        w.ew_countdown = st.ew_red_left;
        w.phase_mark = MARK_CYCLE;
      end
      pending_lamps.push_back(w);
    endfunction

    function void report_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endfunction

    function void check_lamps(tls_result_t got);
      tls_result_t want;
      if (pending_lamps.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result word with none expected, got %h", $time, got);
        return;
      end
      want = pending_lamps.pop_front();
      if (got.ns_lamp !== want.ns_lamp)
        report_field("ns_lamp", want.ns_lamp, got.ns_lamp);
      if (got.ew_lamp !== want.ew_lamp)
        report_field("ew_lamp", want.ew_lamp, got.ew_lamp);
      if (got.ns_countdown !== want.ns_countdown)
        report_field("ns_countdown", want.ns_countdown, got.ns_countdown);
      if (got.ew_countdown !== want.ew_countdown)
        report_field("ew_countdown", want.ew_countdown, got.ew_countdown);
      if (got.phase_mark !== want.phase_mark)
        report_field("phase_mark", want.phase_mark, got.phase_mark);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   src_gap_max = 0;
  int   ticks_sent = 0;
  int   tick_goal;

  tls_in_if  in_ch ();
  tls_out_if out_ch ();
  tls_cfg_if cfg_ch ();

  lamp_scoreboard lamps = new(YELLOW);
  tls_result_t    seen_lamps;

  traffic_light_sequencer_top #(
    .YELLOW_TICKS (YELLOW)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idle limit for one stretch of words: none, short or long gaps
  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 18;
    endcase
  endfunction

  // offer one tick word after a random gap, return once accepted
  task automatic send_tick(input logic t);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    lamps.note_tick(t);
    ticks_sent++;
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    lamps.write_reg(idx, val);
  endtask

  // stop offering, wait for every owed word, then let an idle word leave the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (lamps.pending_lamps.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // result sink with random stalls and two long hold-offs to back up the pipe
  initial begin : result_sink
    int gap;
    int taken;
    int gap_max;
    taken = 0;
    gap_max = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) gap_max = pick_gap_max();
      if (taken == 300 || taken == 1100) gap = LONG_HOLD;
      else gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_lamps = {out_ch.ns_lamp, out_ch.ew_lamp, out_ch.ns_countdown,
                    out_ch.ew_countdown, out_ch.phase_mark};
      lamps.check_lamps(seen_lamps);
    end
  end

  // stimulus
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] t_reg [4];
    int phase_n;
    int burst;
    in_ch.valid  <= 1'b0;
    in_ch.tick   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset times: one whole cycle with an idle word in the middle
    src_gap_max = 2;
    for (int i = 0; i < 17; i++) send_tick(i != 6);
    settle();

    // zero north-south green, red at and past the ceiling, shortest east-west
    // green, and a write to an index outside the register file
    write_reg(REG_NS_GREEN, '0);
    write_reg(REG_NS_RED, CNT_MAX);
    write_reg(REG_EW_GREEN, 7'd1);
    write_reg(REG_EW_RED, 7'd125);
    write_reg({CFG_IDX_W{1'b1}}, '0);
    cfg_ch.valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_tick(1'b1);

    // random phases, each with its own register setting
    tick_goal = ticks_sent + TICK_GOAL;
    phase_n = 0;
    while (ticks_sent < tick_goal) begin
      settle();
      for (int r = 0; r < 4; r++) begin
        case (phase_n)
          0: t_reg[r] = '0;
          1: t_reg[r] = CNT_MAX;
          2: t_reg[r] = 7'd1;
          3: t_reg[r] = 7'd99;
          default: begin
            case ($urandom_range(0, 9))
              0:       t_reg[r] = '0;
              1:       t_reg[r] = CNT_MAX;
              2:       t_reg[r] = CFG_DATA_W'($urandom);
              default: t_reg[r] = CFG_DATA_W'($urandom_range(1, 12));
            endcase
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_EW_RED + 1, {CFG_IDX_W{1'b1}})),
                  CFG_DATA_W'($urandom));
      write_reg(REG_NS_GREEN, t_reg[0]);
      write_reg(REG_NS_RED, t_reg[1]);
      write_reg(REG_EW_GREEN, t_reg[2]);
      write_reg(REG_EW_RED, t_reg[3]);
      cfg_ch.valid <= 1'b0;
      src_gap_max = pick_gap_max();
      burst = $urandom_range(120, 280);
      if (burst > tick_goal - ticks_sent) burst = tick_goal - ticks_sent;
      repeat (burst) send_tick($urandom_range(0, 7) != 0);
      phase_n++;
    end

    settle();
    if (lamps.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
hdl/tls_pkg.sv
hdl/tls_in_if.sv
hdl/tls_out_if.sv
hdl/tls_cfg_if.sv
hdl/tls_cfg_regs.sv
hdl/tls_step.sv
hdl/traffic_light_sequencer_top.sv
sim/tb.sv
